FILE: design/dptp_pkg.sv
`default_nettype none

package dptp_pkg;

  localparam int unsigned PriceW  = 63;
  localparam int unsigned WeightW = 34;  // 9 * 10^9 fits
  localparam int unsigned SumW    = PriceW + 5;

  localparam logic [PriceW-1:0] PriceMax   = {PriceW{1'b1}};
  localparam logic [PriceW-1:0] LimitReset = PriceW'(1510000);

  localparam logic [7:0] ChA       = 8'h41;
  localparam logic [7:0] ChZLow    = 8'h7A;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChPoint   = 8'h2E;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChNul     = 8'h00;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SKIP,
    PH_NUMBER,
    PH_STOP
  } phase_e;

  // finished price handed from the parser to the result stage
  typedef struct packed {
    logic [PriceW-1:0] value;
    logic              ovf;
  } fin_t;

  // powers of ten for digit weights
  function automatic logic [WeightW-1:0] pow10(input logic [3:0] n);
    logic [WeightW-1:0] p;
    case (n)
      4'd0:    p = WeightW'(1);
      4'd1:    p = WeightW'(10);
      4'd2:    p = WeightW'(100);
      4'd3:    p = WeightW'(1000);
      4'd4:    p = WeightW'(10000);
      4'd5:    p = WeightW'(100000);
      4'd6:    p = WeightW'(1000000);
      4'd7:    p = WeightW'(10000000);
      4'd8:    p = WeightW'(100000000);
      4'd9:    p = WeightW'(1000000000);
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: design/dptp_in_if.sv
`default_nettype none

interface dptp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_message;

  modport source (output valid, output byte_value, output end_of_message, input ready);
  modport sink   (input valid, input byte_value, input end_of_message, output ready);
endinterface

`default_nettype wire

FILE: design/dptp_out_if.sv
`default_nettype none

interface dptp_out_if;
  import dptp_pkg::*;

  logic              valid;
  logic              ready;
  logic              buy;
  logic [PriceW-1:0] price_scaled;
  logic              overflow;

  modport source (output valid, output buy, output price_scaled, output overflow,
                  input ready);
  modport sink   (input valid, input buy, input price_scaled, input overflow,
                  output ready);
endinterface

`default_nettype wire

FILE: design/decimal_price_threshold_parser.sv
// channel    dir  words                              handshake
// byte_i     in   byte_value, end_of_message         valid/ready
// result_o   out  buy, price_scaled, overflow        valid/ready
// cfg        in   buy_limit (cfg_wdata_i)            cfg_we_i, no wait
//
// One byte word per cycle is accepted while byte_i.ready is high; a result word
// follows the end_of_message byte: parser register, then limit-compare register.
// Reset clears the parse state and sets buy_limit to 151.0000.
// byte_i.ready drops only when both the finished-price register and the output
// register are full and result_o is stalled.
`default_nettype none

module decimal_price_threshold_parser #(
  parameter int unsigned FRACTION_DIGITS = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  dptp_in_if.sink                          byte_i,
  dptp_out_if.source                       result_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [dptp_pkg::PriceW-1:0] cfg_wdata_i
);
  import dptp_pkg::*;

  // finished price between parser and compare stage
  logic fin_valid;
  logic fin_ready;
  fin_t fin;

  // Parser: tracks the price already scaled to full fraction width, so each
  // digit is one shift-add with a saturation check; no final multiply needed.
  dptp_parse #(
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_parse (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (byte_i.valid),
    .in_ready_o       (byte_i.ready),
    .byte_value_i     (byte_i.byte_value),
    .end_of_message_i (byte_i.end_of_message),
    .fin_valid_o      (fin_valid),
    .fin_ready_i      (fin_ready),
    .fin_o            (fin)
  );

  // Compare against buy_limit and hold the result word.
  dptp_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fin_valid_i (fin_valid),
    .fin_ready_o (fin_ready),
    .fin_i       (fin),
    .res         (result_o)
  );

endmodule

`default_nettype wire

FILE: design/dptp_parse.sv
`default_nettype none

module dptp_parse #(
  parameter int unsigned FRACTION_DIGITS = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    byte_value_i,
  input  wire logic          end_of_message_i,
  output logic               fin_valid_o,
  input  wire logic          fin_ready_i,
  output dptp_pkg::fin_t     fin_o
);
  import dptp_pkg::*;

  localparam int unsigned FcW = (FRACTION_DIGITS > 0) ? $clog2(FRACTION_DIGITS + 1) : 1;
  localparam logic [FcW-1:0] FcMax = FcW'(FRACTION_DIGITS);

  phase_e            phase_q, phase_d;
  logic [PriceW-1:0] scaled_q, scaled_d;   // mantissa already scaled to full fraction
  logic [FcW-1:0]    fc_q, fc_d;
  logic              point_q, point_d;
  logic              sat_q, sat_d;
  logic              fin_valid_q;
  fin_t              fin_q;

  logic              accept;

  assign in_ready_o  = !fin_valid_q || fin_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign fin_valid_o = fin_valid_q;
  assign fin_o       = fin_q;

  always_comb begin
    logic              is_digit;
    logic              is_symbol;
    logic              num_byte;
    logic              add_digit;
    logic [3:0]        exp10;
    logic [WeightW-1:0] weight;
    logic [SumW-1:0]   base;
    logic [SumW-1:0]   sum;

    phase_d  = phase_q;
    scaled_d = scaled_q;
    fc_d     = fc_q;
    point_d  = point_q;
    sat_d    = sat_q;

    is_digit  = (byte_value_i >= ChZero) && (byte_value_i <= ChNine);
    is_symbol = (byte_value_i >= ChA) && (byte_value_i <= ChZLow);
    num_byte  = 1'b0;

    unique case (phase_q)
      PH_FIRST: begin
        if (is_symbol) begin
          phase_d = PH_SKIP;
        end else begin
          phase_d  = PH_NUMBER;
          num_byte = 1'b1;
        end
      end
      PH_SKIP: begin
        if (byte_value_i == ChSpace) begin
          phase_d = PH_NUMBER;
        end else if (byte_value_i == ChNul) begin
          phase_d = PH_STOP;
        end
      end
      PH_NUMBER: num_byte = 1'b1;
      PH_STOP:   ;
      default:   ;
    endcase

    // integer digit: x10 plus d*10^F; fraction digit: plus d*10^(F-1-fc)
    add_digit = num_byte && is_digit && (!point_q || (fc_q < FcMax));
    exp10     = point_q ? (4'(FRACTION_DIGITS - 1) - 4'(fc_q)) : 4'(FRACTION_DIGITS);
    weight    = WeightW'(byte_value_i[3:0] * pow10(exp10));
    base      = point_q ? SumW'(scaled_q)
                        : (SumW'(scaled_q) << 3) + (SumW'(scaled_q) << 1);
    sum       = base + SumW'(weight);

    if (add_digit) begin
      scaled_d = sum[PriceW-1:0];
      sat_d    = sat_q || (sum[SumW-1:PriceW] != '0);
      if (point_q) begin
        fc_d = fc_q + FcW'(1);
      end
    end

    if (num_byte && !is_digit) begin
      if (byte_value_i == ChPoint) begin
        point_d = 1'b1;
      end else if ((byte_value_i == ChSpace) || (byte_value_i == ChNewline) ||
                   (byte_value_i == ChNul)) begin
        phase_d = PH_STOP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIRST;
      scaled_q    <= '0;
      fc_q        <= '0;
      point_q     <= 1'b0;
      sat_q       <= 1'b0;
      fin_valid_q <= 1'b0;
    end else begin
      if (accept && end_of_message_i) begin
        fin_valid_q <= 1'b1;
      end else if (fin_ready_i) begin
        fin_valid_q <= 1'b0;
      end
      if (accept) begin
        if (end_of_message_i) begin
          phase_q  <= PH_FIRST;
          scaled_q <= '0;
          fc_q     <= '0;
          point_q  <= 1'b0;
          sat_q    <= 1'b0;
        end else begin
          phase_q  <= phase_d;
          scaled_q <= scaled_d;
          fc_q     <= fc_d;
          point_q  <= point_d;
          sat_q    <= sat_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && end_of_message_i) begin
      fin_q.value <= sat_d ? PriceMax : scaled_d;
      fin_q.ovf   <= sat_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/dptp_result.sv
`default_nettype none

module dptp_result (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [dptp_pkg::PriceW-1:0] cfg_wdata_i,
  input  wire logic                        fin_valid_i,
  output logic                             fin_ready_o,
  input  wire dptp_pkg::fin_t              fin_i,
  dptp_out_if.source                       res
);
  import dptp_pkg::*;

  logic [PriceW-1:0] limit_q;
  logic              out_valid_q;
  logic              buy_q;
  logic [PriceW-1:0] price_q;
  logic              ovf_q;
  logic              take;

  assign fin_ready_o = !out_valid_q || res.ready;
  assign take        = fin_valid_i && fin_ready_o;

  assign res.valid        = out_valid_q;
  assign res.buy          = buy_q;
  assign res.price_scaled = price_q;
  assign res.overflow     = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LimitReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (res.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      buy_q   <= (fin_i.value != '0) && (fin_i.value < limit_q);
      price_q <= fin_i.value;
      ovf_q   <= fin_i.ovf;
    end
  end

endmodule

`default_nettype wire
